// ===== rtl/gpps_pkg.sv =====
// gpps_pkg: shared widths, constants and codes for the playback position stepper
// no dependencies; used by gpps_step and grain_playback_position_stepper
`default_nettype none

package gpps_pkg;

	// field widths
	localparam int SPEED_BITS     = 16;
	localparam int MOD_BITS       = 16;
	localparam int BUF_BITS       = 20;
	localparam int MODE_BITS      = 2;
	localparam int STATE_POS_BITS = 22;
	localparam int FRAC_BITS      = 10;

	// step and accumulator widths
	localparam int STEP_BITS      = 18;
	localparam int SUM_BITS       = 18;
	localparam int WHOLE_BITS     = 8;
	localparam int REM_BITS       = 11;
	localparam int MOVE_BITS      = WHOLE_BITS + 1;

	// q2.14 modulation scaling
	localparam int MOD_FRAC_BITS  = 14;

	// divide by one thousand as multiply by 1048 / 2^20, then one correction
	localparam int STEP_UNIT      = 1000;
	localparam int RECIP_UNIT     = 1048;
	localparam int RECIP_BITS     = 11;
	localparam int RECIP_SHIFT    = 20;
	localparam int RECIP_PROD_BITS = SUM_BITS + RECIP_BITS;

	localparam int END_MARGIN     = 4;

	localparam int POSITION_BITS_DEF = 21;
	localparam int BUF_SIZE_RESET    = 4000;

	typedef enum logic [MODE_BITS-1:0] {
		LOOP_FORWARD  = 2'd0,
		LOOP_REVERSE  = 2'd1,
		LOOP_PINGPONG = 2'd2
	} loop_mode_t;

	typedef enum logic {
		CFG_BUFFER_SIZE = 1'b0,
		CFG_LOOP_MODE   = 1'b1
	} cfg_index_t;

endpackage

`default_nettype wire

// ===== rtl/gpps_step.sv =====
// gpps_step: forms the per-tick step, speed plus speed times a q2.14 factor, clamped at zero
// depends on gpps_pkg
`default_nettype none

module gpps_step (
	input  wire logic [gpps_pkg::SPEED_BITS-1:0]   speed,
	input  wire logic signed [gpps_pkg::MOD_BITS-1:0] pitch_mod,
	output logic      [gpps_pkg::STEP_BITS-1:0]    step
);

	localparam int PROD_BITS = gpps_pkg::SPEED_BITS + 1 + gpps_pkg::MOD_BITS;
	localparam int Q_BITS    = PROD_BITS - gpps_pkg::MOD_FRAC_BITS;
	localparam int FULL_BITS = gpps_pkg::STEP_BITS + 2;

	logic signed [PROD_BITS-1:0] prod;
	logic signed [PROD_BITS-1:0] biased;
	logic signed [Q_BITS-1:0]    quot;
	logic signed [FULL_BITS-1:0] step_full;

	always_comb begin
		prod = PROD_BITS'($signed({1'b0, speed}) * pitch_mod);
		// bias negative products so the shift truncates toward zero
		if (prod[PROD_BITS-1]) begin
			biased = prod + PROD_BITS'((1 << gpps_pkg::MOD_FRAC_BITS) - 1);
		end else begin
			biased = prod;
		end
		quot = biased[PROD_BITS-1:gpps_pkg::MOD_FRAC_BITS];
		step_full = $signed(FULL_BITS'({1'b0, speed})) + FULL_BITS'(quot);
		if (step_full[FULL_BITS-1]) begin
			step = '0;
		end else begin
			step = step_full[gpps_pkg::STEP_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/grain_playback_position_stepper.sv =====
// grain_playback_position_stepper: sample loop playback position stepper, top level
// depends on gpps_pkg and gpps_step
`default_nettype none

// Steps a sample-loop playback position once per accepted item (one audio tick).
// Each item carries a base speed (1000 = one frame per tick) and a signed q2.14
// pitch modulation; the step is speed + trunc(speed * mod), clamped at zero, and
// is added to a fraction kept modulo 1000. The whole part, doubled for
// interleaved stereo words, moves the position according to loop_mode: forward
// wraps to 0 at buffer_size - 4, reverse reloads buffer_size at 4 or below,
// ping-pong flips direction at either end. A wrap clears the fraction and
// raises wrapped. One item is accepted every cycle unless in_stall is high
// (stage one full, result register stalled). Stage one registers the step
// from the 17x16 multiply; the result register loads from it when free or
// being drained, raising out_valid. Stage two closes the fraction and
// position loop (add, reciprocal divide by 1000, end compare) combinationally.
// The user must write registers through the config channel while the block is idle;
// the block itself does not enforce this. cfg_ready is always high.
module grain_playback_position_stepper #(
	parameter int POSITION_BITS = gpps_pkg::POSITION_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic                                 cfg_index,
	input  wire logic [gpps_pkg::BUF_BITS-1:0]        cfg_data,

	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [gpps_pkg::SPEED_BITS-1:0]      speed,
	input  wire logic signed [gpps_pkg::MOD_BITS-1:0] pitch_mod,

	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [POSITION_BITS-1:0]                  position,
	output logic                                      wrapped
);

	localparam int SP   = gpps_pkg::STATE_POS_BITS;
	localparam int EXT  = 32;
	localparam int CMPW = SP + 2;

	// configuration
	logic [gpps_pkg::BUF_BITS-1:0] buffer_size_q;
	gpps_pkg::loop_mode_t          loop_mode_q;

	// loop state
	logic [gpps_pkg::FRAC_BITS-1:0] fraction_q;
	logic [SP-1:0]                  play_pos_q;
	logic                           backward_q;

	// stage one and result register
	logic                            s1_valid_q;
	logic [gpps_pkg::STEP_BITS-1:0]  step_s1;
	logic                            out_valid_q;
	logic [SP-1:0]                   res_pos_q;
	logic                            wrapped_q;

	logic [gpps_pkg::STEP_BITS-1:0]  step_new;
	logic                            out_free;
	logic                            s1_adv;
	logic                            in_take;

	// stage two datapath
	logic [gpps_pkg::SUM_BITS-1:0]        sum;
	logic [gpps_pkg::RECIP_PROD_BITS-1:0] recip_prod;
	logic [gpps_pkg::WHOLE_BITS-1:0]      whole_est;
	logic [gpps_pkg::SUM_BITS-1:0]        rem_full;
	logic [gpps_pkg::REM_BITS-1:0]        rem;
	logic [gpps_pkg::WHOLE_BITS-1:0]      whole;
	logic [gpps_pkg::FRAC_BITS-1:0]       frac_step;
	logic [gpps_pkg::MOVE_BITS-1:0]       move;
	logic [SP:0]                          pos_fwd;
	logic signed [SP:0]                   pos_rev;
	logic                                 hit_top;
	logic                                 hit_bottom;

	logic [gpps_pkg::FRAC_BITS-1:0] frac_next;
	logic [SP-1:0]                  pos_next;
	logic                           back_next;
	logic                           hit;
	logic [EXT-1:0]                 pos_ext;

	gpps_step u_step (
		.speed     (speed),
		.pitch_mod (pitch_mod),
		.step      (step_new)
	);

	// handshake: stage one moves on when the result register is free or being drained
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_adv    = s1_valid_q && out_free;
	assign in_stall  = s1_valid_q && !out_free;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		sum        = gpps_pkg::SUM_BITS'(fraction_q) + step_s1;
		// reciprocal estimate is exact or one short, fixed by the compare below
		recip_prod = gpps_pkg::RECIP_PROD_BITS'(sum)
			* gpps_pkg::RECIP_PROD_BITS'(gpps_pkg::RECIP_UNIT);
		whole_est  = recip_prod[gpps_pkg::RECIP_SHIFT +: gpps_pkg::WHOLE_BITS];
		rem_full   = sum - gpps_pkg::SUM_BITS'(gpps_pkg::SUM_BITS'(whole_est)
			* gpps_pkg::SUM_BITS'(gpps_pkg::STEP_UNIT));
		rem        = rem_full[gpps_pkg::REM_BITS-1:0];
		if (rem >= gpps_pkg::REM_BITS'(gpps_pkg::STEP_UNIT)) begin
			whole     = whole_est + 1'b1;
			frac_step = gpps_pkg::FRAC_BITS'(rem - gpps_pkg::REM_BITS'(gpps_pkg::STEP_UNIT));
		end else begin
			whole     = whole_est;
			frac_step = rem[gpps_pkg::FRAC_BITS-1:0];
		end
		// two interleaved words per frame
		move = {whole, 1'b0};

		pos_fwd = {1'b0, play_pos_q} + (SP+1)'(move);
		pos_rev = $signed({1'b0, play_pos_q}) - $signed((SP+1)'(move));
		// end test without wrap, so a buffer below the margin hits every tick
		hit_top = (CMPW'(pos_fwd) + CMPW'(gpps_pkg::END_MARGIN)) >= CMPW'(buffer_size_q);
		hit_bottom = pos_rev[SP] || (pos_rev[SP-1:0] <= SP'(gpps_pkg::END_MARGIN));

		frac_next = frac_step;
		pos_next  = play_pos_q;
		back_next = backward_q;
		hit       = 1'b0;
		unique case (loop_mode_q)
			gpps_pkg::LOOP_FORWARD: begin
				if (hit_top) begin
					pos_next  = '0;
					frac_next = '0;
					hit       = 1'b1;
				end else begin
					pos_next = pos_fwd[SP-1:0];
				end
			end
			gpps_pkg::LOOP_REVERSE: begin
				if (hit_bottom) begin
					pos_next  = SP'(buffer_size_q);
					frac_next = '0;
					hit       = 1'b1;
				end else begin
					pos_next = pos_rev[SP-1:0];
				end
			end
			gpps_pkg::LOOP_PINGPONG: begin
				if (!backward_q) begin
					// position kept as it lands, even past the end
					pos_next = pos_fwd[SP-1:0];
					if (hit_top) begin
						back_next = 1'b1;
						frac_next = '0;
						hit       = 1'b1;
					end
				end else if (hit_bottom) begin
					pos_next  = '0;
					back_next = 1'b0;
					frac_next = '0;
					hit       = 1'b1;
				end else begin
					pos_next = pos_rev[SP-1:0];
				end
			end
			default: begin
				// unused mode: fraction still runs, position and direction hold
			end
		endcase
	end

	// control, configuration and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= gpps_pkg::BUF_BITS'(gpps_pkg::BUF_SIZE_RESET);
			loop_mode_q   <= gpps_pkg::LOOP_FORWARD;
			fraction_q    <= '0;
			play_pos_q    <= '0;
			backward_q    <= 1'b0;
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == gpps_pkg::CFG_BUFFER_SIZE) begin
					buffer_size_q <= cfg_data;
				end else begin
					loop_mode_q <= gpps_pkg::loop_mode_t'(cfg_data[gpps_pkg::MODE_BITS-1:0]);
				end
			end

			if (in_take) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_adv) begin
				out_valid_q <= 1'b1;
				fraction_q  <= frac_next;
				play_pos_q  <= pos_next;
				backward_q  <= back_next;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			step_s1 <= step_new;
		end
		if (s1_adv) begin
			res_pos_q <= pos_next;
			wrapped_q <= hit;
		end
	end

	// position port is the low bits of the state, zero padded when wider
	assign pos_ext   = EXT'(res_pos_q);
	assign position  = pos_ext[POSITION_BITS-1:0];
	assign wrapped   = wrapped_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
